FILE: hdl/rpis_pkg.sv
// Shared types and constants of the RANSAC plane inlier search unit.
// No dependencies; used by the top level and by rpis_mac.
package rpis_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_W    = 18;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int THR_W      = 17;

    localparam int MAC_A_W    = 64;
    localparam int MAC_B_W    = 80;
    localparam int MAC_P_W    = 128;
    localparam int MAC_DIG_W  = 20;

    localparam logic [1:0] OPC_CLEAR = 2'd0;
    localparam logic [1:0] OPC_LOAD  = 2'd1;
    localparam logic [1:0] OPC_TRIAL = 2'd2;
    localparam logic [1:0] OPC_QUERY = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_BAD  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic       clear;
        logic       negate;
        logic [1:0] last_digit;
    } mac_cmd_t;

endpackage

FILE: hdl/rpis_mac.sv
// Shared signed multiply-accumulate unit: 64-bit by 80-bit, one 20-bit digit per cycle.
// Depends on rpis_pkg.
module rpis_mac
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  rpis_pkg::mac_cmd_t                cmd,
    input  logic signed [rpis_pkg::MAC_A_W-1:0] op_a,
    input  logic signed [rpis_pkg::MAC_B_W-1:0] op_b,
    output logic                              busy,
    output logic [rpis_pkg::MAC_P_W-1:0]      acc
);

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_ADD} mstate_t;

    localparam int PART_W = rpis_pkg::MAC_A_W + rpis_pkg::MAC_DIG_W;

    mstate_t                          state_reg;
    logic [rpis_pkg::MAC_A_W-1:0]     mag_a_reg;
    logic [rpis_pkg::MAC_B_W-1:0]     mag_b_reg;
    logic [rpis_pkg::MAC_P_W-1:0]     prod_reg;
    logic [rpis_pkg::MAC_P_W-1:0]     acc_reg;
    logic [1:0]                       dig_reg;
    logic                             neg_reg;
    logic                             clear_reg;
    logic [rpis_pkg::MAC_DIG_W-1:0]   digit;
    logic [PART_W-1:0]                partial;
    logic [rpis_pkg::MAC_P_W-1:0]     base;

    always_comb
    begin
        case (dig_reg)
            2'd0:    digit = mag_b_reg[19:0];
            2'd1:    digit = mag_b_reg[39:20];
            2'd2:    digit = mag_b_reg[59:40];
            default: digit = mag_b_reg[79:60];
        endcase
        partial = PART_W'(mag_a_reg) * PART_W'(digit);
        base    = clear_reg ? '0 : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            acc_reg   <= '0;
            mag_a_reg <= '0;
            mag_b_reg <= '0;
            prod_reg  <= '0;
            dig_reg   <= '0;
            neg_reg   <= 1'b0;
            clear_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        mag_a_reg <= op_a[rpis_pkg::MAC_A_W-1] ? -op_a : op_a;
                        mag_b_reg <= op_b[rpis_pkg::MAC_B_W-1] ? -op_b : op_b;
                        neg_reg   <= op_a[rpis_pkg::MAC_A_W-1] ^ op_b[rpis_pkg::MAC_B_W-1]
                                     ^ cmd.negate;
                        clear_reg <= cmd.clear;
                        dig_reg   <= cmd.last_digit;
                        prod_reg  <= '0;
                        state_reg <= M_MUL;
                    end
                end
                M_MUL:
                begin
                    prod_reg <= (prod_reg << rpis_pkg::MAC_DIG_W)
                                + rpis_pkg::MAC_P_W'(partial);
                    if (dig_reg == 2'd0)
                        state_reg <= M_ADD;
                    else
                        dig_reg <= dig_reg - 2'd1;
                end
                M_ADD:
                begin
                    acc_reg   <= neg_reg ? (base - prod_reg) : (base + prod_reg);
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != M_IDLE);
    assign acc  = acc_reg;

endmodule

FILE: hdl/ransac_plane_inlier_search_unit.sv
// RANSAC plane inlier search: point store, trial sequencer, best-set masks.
// Depends on rpis_pkg and rpis_mac.
//
// Requests enter on s_* (opcode in s_tuser), one result per request leaves on m_*
// (status in m_tuser). cfg_* writes the distance threshold; always ready, use only
// while the unit is idle.
// s_tready is high only while the sequencer is idle; one request is worked at a time.
// Clear and load pass from idle through the result state to the output register.
// Query reads the best-set mask (ST_QUERY, ST_QUERY_DATA) before the result state.
// Trial: plane set-up, then per stored point a distance test, or only a mark step
// for a sampled point or a degenerate trio. Every product goes through the shared
// multiply-accumulate unit one 20-bit digit per cycle.
// The result sits in an output register; a new request may be taken while it waits,
// and the unit only holds at its next result until m_tready clears the register.
// Reset (rst_n low, asynchronous) empties the store and the best set and restores the
// threshold to 102. No clearing pass is needed: stale mask rows are never read.
module ransac_plane_inlier_search_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // x_coord, y_coord, z_coord, first_index, second_index, third_index
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // trial_inliers, best_inliers, loaded_points, is_inlier
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_MAC_GO, ST_MAC_WAIT,
        ST_PT_ADDR, ST_PT_DATA, ST_PT_MARK, ST_QUERY, ST_QUERY_DATA, ST_RESULT
    } state_t;

    typedef enum logic [3:0] {
        OP_AX_P, OP_AX_N, OP_BY_P, OP_BY_N, OP_CZ_P, OP_CZ_N,
        OP_NA, OP_NB, OP_NC, OP_T2, OP_RHS, OP_DX, OP_DY, OP_DZ, OP_SQ
    } mac_op_t;

    localparam int PT_W = 3 * rpis_pkg::COORD_W;

    state_t                         state_reg;
    mac_op_t                        op_reg;
    logic [rpis_pkg::THR_W-1:0]     thr_reg;
    logic [rpis_pkg::CNT_W-1:0]     count_reg;
    logic [rpis_pkg::CNT_W-1:0]     best_cnt_reg;
    logic [rpis_pkg::CNT_W-1:0]     best_len_reg;
    logic                           best_sel_reg;
    logic [rpis_pkg::CNT_W-1:0]     k_reg;
    logic [rpis_pkg::CNT_W-1:0]     trial_cnt_reg;
    logic [1:0]                     res_status_reg;
    logic [rpis_pkg::CNT_W-1:0]     res_trial_reg;
    logic                           res_member_reg;
    logic                           m_tvalid_reg;
    logic [39:0]                    m_tdata_reg;
    logic [1:0]                     m_tuser_reg;

    logic [rpis_pkg::IDX_W-1:0]     i1_reg, i2_reg, i3_reg;
    logic signed [17:0]             x1_reg, y1_reg, z1_reg;
    logic signed [18:0]             ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [18:0]             dx_reg, dy_reg, dz_reg;
    logic signed [38:0]             a_reg, b_reg, c_reg;
    logic signed [79:0]             norm_reg;
    logic [33:0]                    t2_reg;
    logic [111:0]                   rhs_reg;
    logic signed [57:0]             num_reg;
    logic                           degen_reg;
    logic                           inl_reg;

    logic [PT_W-1:0]                point_mem [rpis_pkg::MAX_POINTS];
    logic [PT_W-1:0]                pt_rd_reg;
    logic                           mask_mem [2 * rpis_pkg::MAX_POINTS];
    logic                           mask_rd_reg;

    logic [rpis_pkg::IDX_W-1:0]     in_i1, in_i2, in_i3;
    logic                           accept, trial_bad, special;
    logic [rpis_pkg::IDX_W-1:0]     pt_addr;
    logic signed [17:0]             rd_x, rd_y, rd_z;
    logic signed [18:0]             rd_dx, rd_dy, rd_dz;

    logic                           mac_start;
    rpis_pkg::mac_cmd_t             mac_cmd;
    logic signed [rpis_pkg::MAC_A_W-1:0] mac_a;
    logic signed [rpis_pkg::MAC_B_W-1:0] mac_b;
    logic                           mac_busy;
    logic [rpis_pkg::MAC_P_W-1:0]   mac_acc;

    assign in_i1  = s_tdata[63:54];
    assign in_i2  = s_tdata[73:64];
    assign in_i3  = s_tdata[83:74];
    assign accept = s_tvalid && s_tready;

    assign trial_bad = ({1'b0, in_i1} >= count_reg) || ({1'b0, in_i2} >= count_reg)
                    || ({1'b0, in_i3} >= count_reg) || (in_i1 == in_i2)
                    || (in_i1 == in_i3) || (in_i2 == in_i3);

    assign special = (k_reg == {1'b0, i1_reg}) || (k_reg == {1'b0, i2_reg})
                  || (k_reg == {1'b0, i3_reg});

    assign rd_x  = signed'(pt_rd_reg[17:0]);
    assign rd_y  = signed'(pt_rd_reg[35:18]);
    assign rd_z  = signed'(pt_rd_reg[53:36]);
    assign rd_dx = 19'(rd_x) - 19'(x1_reg);
    assign rd_dy = 19'(rd_y) - 19'(y1_reg);
    assign rd_dz = 19'(rd_z) - 19'(z1_reg);

    always_comb
    begin
        case (state_reg)
            ST_RD1:  pt_addr = i1_reg;
            ST_RD2:  pt_addr = i2_reg;
            ST_RD3:  pt_addr = i3_reg;
            default: pt_addr = k_reg[rpis_pkg::IDX_W-1:0];
        endcase
    end

    // operand routing for the shared unit
    always_comb
    begin
        mac_start       = (state_reg == ST_MAC_GO);
        mac_cmd.clear   = 1'b0;
        mac_cmd.negate  = 1'b0;
        mac_cmd.last_digit = 2'd0;
        mac_a = '0;
        mac_b = '0;
        case (op_reg)
            OP_AX_P: begin mac_a = 64'(uy_reg); mac_b = 80'(vz_reg); mac_cmd.clear = 1'b1; end
            OP_AX_N: begin mac_a = 64'(uz_reg); mac_b = 80'(vy_reg); mac_cmd.negate = 1'b1; end
            OP_BY_P: begin mac_a = 64'(uz_reg); mac_b = 80'(vx_reg); mac_cmd.clear = 1'b1; end
            OP_BY_N: begin mac_a = 64'(ux_reg); mac_b = 80'(vz_reg); mac_cmd.negate = 1'b1; end
            OP_CZ_P: begin mac_a = 64'(ux_reg); mac_b = 80'(vy_reg); mac_cmd.clear = 1'b1; end
            OP_CZ_N: begin mac_a = 64'(uy_reg); mac_b = 80'(vx_reg); mac_cmd.negate = 1'b1; end
            OP_NA:
            begin
                mac_a = 64'(a_reg); mac_b = 80'(a_reg);
                mac_cmd.clear = 1'b1; mac_cmd.last_digit = 2'd1;
            end
            OP_NB:   begin mac_a = 64'(b_reg); mac_b = 80'(b_reg); mac_cmd.last_digit = 2'd1; end
            OP_NC:   begin mac_a = 64'(c_reg); mac_b = 80'(c_reg); mac_cmd.last_digit = 2'd1; end
            OP_T2:
            begin
                mac_a = signed'({47'd0, thr_reg}); mac_b = signed'({63'd0, thr_reg});
                mac_cmd.clear = 1'b1;
            end
            OP_RHS:
            begin
                mac_a = signed'({30'd0, t2_reg}); mac_b = norm_reg;
                mac_cmd.clear = 1'b1; mac_cmd.last_digit = 2'd3;
            end
            OP_DX:   begin mac_a = 64'(a_reg); mac_b = 80'(dx_reg); mac_cmd.clear = 1'b1; end
            OP_DY:   begin mac_a = 64'(b_reg); mac_b = 80'(dy_reg); end
            OP_DZ:   begin mac_a = 64'(c_reg); mac_b = 80'(dz_reg); end
            OP_SQ:
            begin
                mac_a = 64'(num_reg); mac_b = 80'(num_reg);
                mac_cmd.clear = 1'b1; mac_cmd.last_digit = 2'd2;
            end
            default: mac_a = '0;
        endcase
    end

    rpis_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start),
        .cmd   (mac_cmd),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .busy  (mac_busy),
        .acc   (mac_acc)
    );

    // point store
    always_ff @(posedge clk)
    begin
        if (accept && (s_tuser == rpis_pkg::OPC_LOAD) && !count_reg[rpis_pkg::CNT_W-1])
            point_mem[count_reg[rpis_pkg::IDX_W-1:0]] <= s_tdata[PT_W-1:0];
        pt_rd_reg <= point_mem[pt_addr];
    end

    // two mask banks: best set and the trial being built
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PT_MARK)
            mask_mem[{~best_sel_reg, k_reg[rpis_pkg::IDX_W-1:0]}] <= inl_reg;
        mask_rd_reg <= mask_mem[{best_sel_reg, i1_reg}];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    i1_reg <= in_i1;
                    i2_reg <= in_i2;
                    i3_reg <= in_i3;
                end
            end
            ST_RD2:
            begin
                x1_reg <= rd_x;
                y1_reg <= rd_y;
                z1_reg <= rd_z;
            end
            ST_RD3:
            begin
                ux_reg <= rd_dx;
                uy_reg <= rd_dy;
                uz_reg <= rd_dz;
            end
            ST_RD4:
            begin
                vx_reg <= rd_dx;
                vy_reg <= rd_dy;
                vz_reg <= rd_dz;
            end
            ST_MAC_WAIT:
            begin
                if (!mac_busy)
                begin
                    case (op_reg)
                        OP_AX_N: a_reg <= signed'(mac_acc[38:0]);
                        OP_BY_N: b_reg <= signed'(mac_acc[38:0]);
                        OP_CZ_N: c_reg <= signed'(mac_acc[38:0]);
                        OP_NC:
                        begin
                            norm_reg  <= signed'(mac_acc[79:0]);
                            degen_reg <= (mac_acc[79:0] == '0);
                        end
                        OP_T2:   t2_reg  <= mac_acc[33:0];
                        OP_RHS:  rhs_reg <= mac_acc[111:0];
                        OP_DZ:   num_reg <= signed'(mac_acc[57:0]);
                        OP_SQ:   inl_reg <= (mac_acc <= rpis_pkg::MAC_P_W'(rhs_reg));
                        default: inl_reg <= inl_reg;
                    endcase
                end
            end
            ST_PT_DATA:
            begin
                dx_reg  <= rd_dx;
                dy_reg  <= rd_dy;
                dz_reg  <= rd_dz;
                inl_reg <= special;
            end
            default: inl_reg <= inl_reg;
        endcase
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_AX_P;
            thr_reg        <= 17'd102;
            count_reg      <= '0;
            best_cnt_reg   <= '0;
            best_len_reg   <= '0;
            best_sel_reg   <= 1'b0;
            k_reg          <= '0;
            trial_cnt_reg  <= '0;
            res_status_reg <= rpis_pkg::STAT_OK;
            res_trial_reg  <= '0;
            res_member_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
                thr_reg <= cfg_data;
            if (m_tvalid_reg && m_tready && (state_reg != ST_RESULT))
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_trial_reg  <= '0;
                        res_member_reg <= 1'b0;
                        case (s_tuser)
                            rpis_pkg::OPC_CLEAR:
                            begin
                                count_reg      <= '0;
                                best_cnt_reg   <= '0;
                                best_len_reg   <= '0;
                                res_status_reg <= rpis_pkg::STAT_OK;
                                state_reg      <= ST_RESULT;
                            end
                            rpis_pkg::OPC_LOAD:
                            begin
                                if (count_reg[rpis_pkg::CNT_W-1])
                                begin
                                    res_status_reg <= rpis_pkg::STAT_FULL;
                                end
                                else
                                begin
                                    count_reg      <= count_reg + 1'b1;
                                    res_status_reg <= rpis_pkg::STAT_OK;
                                end
                                state_reg <= ST_RESULT;
                            end
                            rpis_pkg::OPC_TRIAL:
                            begin
                                if (trial_bad)
                                begin
                                    res_status_reg <= rpis_pkg::STAT_BAD;
                                    state_reg      <= ST_RESULT;
                                end
                                else
                                begin
                                    res_status_reg <= rpis_pkg::STAT_OK;
                                    state_reg      <= ST_RD1;
                                end
                            end
                            default:
                            begin
                                if ({1'b0, in_i1} >= count_reg)
                                begin
                                    res_status_reg <= rpis_pkg::STAT_BAD;
                                    state_reg      <= ST_RESULT;
                                end
                                else
                                begin
                                    res_status_reg <= rpis_pkg::STAT_OK;
                                    state_reg      <= ST_QUERY;
                                end
                            end
                        endcase
                    end
                end
                ST_RD1: state_reg <= ST_RD2;
                ST_RD2: state_reg <= ST_RD3;
                ST_RD3: state_reg <= ST_RD4;
                ST_RD4:
                begin
                    op_reg    <= OP_AX_P;
                    state_reg <= ST_MAC_GO;
                end
                ST_MAC_GO: state_reg <= ST_MAC_WAIT;
                ST_MAC_WAIT:
                begin
                    if (!mac_busy)
                    begin
                        if (op_reg == OP_RHS)
                        begin
                            k_reg         <= '0;
                            trial_cnt_reg <= '0;
                            state_reg     <= ST_PT_ADDR;
                        end
                        else if (op_reg == OP_SQ)
                        begin
                            state_reg <= ST_PT_MARK;
                        end
                        else
                        begin
                            op_reg    <= mac_op_t'(op_reg + 4'd1);
                            state_reg <= ST_MAC_GO;
                        end
                    end
                end
                ST_PT_ADDR:
                begin
                    if (k_reg == count_reg)
                    begin
                        res_trial_reg <= trial_cnt_reg;
                        if (trial_cnt_reg > best_cnt_reg)
                        begin
                            best_cnt_reg <= trial_cnt_reg;
                            best_len_reg <= count_reg;
                            best_sel_reg <= ~best_sel_reg;
                        end
                        state_reg <= ST_RESULT;
                    end
                    else
                    begin
                        state_reg <= ST_PT_DATA;
                    end
                end
                ST_PT_DATA:
                begin
                    if (special || degen_reg)
                    begin
                        state_reg <= ST_PT_MARK;
                    end
                    else
                    begin
                        op_reg    <= OP_DX;
                        state_reg <= ST_MAC_GO;
                    end
                end
                ST_PT_MARK:
                begin
                    trial_cnt_reg <= trial_cnt_reg + rpis_pkg::CNT_W'(inl_reg);
                    k_reg         <= k_reg + 1'b1;
                    state_reg     <= ST_PT_ADDR;
                end
                ST_QUERY: state_reg <= ST_QUERY_DATA;
                ST_QUERY_DATA:
                begin
                    res_member_reg <= mask_rd_reg && ({1'b0, i1_reg} < best_len_reg);
                    state_reg      <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, res_member_reg, count_reg, best_cnt_reg,
                                         res_trial_reg};
                        m_tuser_reg  <= res_status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign cfg_ready = 1'b1;

endmodule

FILE: hdl/rpis_checker.sv
// Port-level checks of the RANSAC plane inlier search unit, bound to its top level.
// Depends on ransac_plane_inlier_search_unit.
module rpis_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_best_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[21:11] <= m_tdata[32:22])
        else $error("best count above loaded count");

    a_member_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33] |-> m_tuser == 2'd0 && m_tdata[10:0] == 11'd0)
        else $error("membership flag on a non-query result");

endmodule

bind ransac_plane_inlier_search_unit rpis_checker u_rpis_checker (.*);
